@@ src/lndp_pkg.sv @@
// Package for the L1 nearest descriptor picker: constants, types and codes.
package lndp_pkg;

   localparam int MAX_ENTRIES_DEF = 256;
   localparam int DESC_LEN_DEF    = 48;

   localparam int DIST_W   = 14;
   localparam int ELEM_W   = 8;
   localparam int RND_W    = 31;
   localparam int CSR_W    = 14;
   localparam int CSR_IDX_W = 2;
   localparam int DVS_W    = 16;
   localparam int REM_CNT_W = 5;

   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 24;

   localparam logic [DIST_W-1:0] DIST_MAX = 14'h3FFF;

   localparam logic [13:0] THR_RST    = 14'd700;
   localparam logic [7:0]  TIGHT_RST  = 8'd2;
   localparam logic [7:0]  STEP_RST   = 8'd10;
   localparam logic [8:0]  MINC_RST   = 9'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_MATCH_THR  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIGHT      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP       = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_CAND   = 2'd3;

   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic KIND_ADD   = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FILL,
      ST_FINISH,
      ST_DIST,
      ST_GATHER,
      ST_DIV,
      ST_MOD,
      ST_PICK,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic             start;
      logic [RND_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } rem_req_type;

   typedef struct packed {
      logic             done;
      logic [DVS_W-1:0] remainder;
   } rem_rsp_type;

endpackage

@@ src/lndp_ram.sv @@
// Generic simple dual-port RAM with registered read.
module lndp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                                  clock,
   input  logic                                  we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                      wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                      rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ src/lndp_rem.sv @@
// Bit-serial restoring remainder unit, one dividend bit per cycle.
module lndp_rem (
   input  logic                 clock,
   input  logic                 reset,
   input  lndp_pkg::rem_req_type req,
   output lndp_pkg::rem_rsp_type rsp
);

   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [lndp_pkg::REM_CNT_W-1:0]      cnt_ff, cnt_in;
   logic [lndp_pkg::DVS_W-1:0]          rem_ff, rem_in;
   logic [lndp_pkg::DVS_W-1:0]          dvs_ff, dvs_in;
   logic [lndp_pkg::RND_W-1:0]          dvd_ff, dvd_in;
   logic [lndp_pkg::DVS_W:0]            trial;

   assign trial = {rem_ff, dvd_ff[lndp_pkg::RND_W-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      dvd_in  = dvd_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvs_in  = req.divisor;
         dvd_in  = req.dividend;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = lndp_pkg::DVS_W'(trial - {1'b0, dvs_ff});
         end else begin
            rem_in = lndp_pkg::DVS_W'(trial);
         end
         dvd_in = {dvd_ff[lndp_pkg::RND_W-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == lndp_pkg::REM_CNT_W'(lndp_pkg::RND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      dvd_ff <= dvd_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.remainder = rem_ff;

endmodule

@@ src/l1_nearest_descriptor_picker_unit.sv @@
// Top level: descriptor table, L1 distance pass, candidate gathering and random pick.
//
//   channel | ports     | carries
//   --------+-----------+----------------------------------------------
//   request | req_*     | descriptor elements for an add or a query
//   result  | rsp_*     | one transaction per completed add or query
//   config  | csr_*     | register writes, no read-back
//
// A non-last element is only stored. A last element passes through a fill state for each unwritten
// position, then a finish state and an emit state. A query on a nonempty table adds a distance
// pass over every stored element, gather scans over the entries and one pick scan, with a
// serial remainder for the pick and for each widening after the first.
// Synchronous active-high reset empties the table; no clearing pass is needed.
// A waiting result does not block requests; only the next result waits for rsp_tready.
module l1_nearest_descriptor_picker_unit #(
   parameter int MAX_ENTRIES = lndp_pkg::MAX_ENTRIES_DEF,
   parameter int DESC_LEN    = lndp_pkg::DESC_LEN_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [lndp_pkg::REQ_TDATA_W-1:0]    req_tdata,  // element[7:0], random_value[38:8]
   input  logic                                req_tuser,  // operation
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // entry_index[7:0], pick_distance[21:8], matched[22], table_full[23]
   output logic [lndp_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic                                rsp_tuser,  // result_kind
   input  logic                                csr_wr_en,
   input  logic [lndp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lndp_pkg::CSR_W-1:0]          csr_wdata
);

   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int POS_W = $clog2(DESC_LEN + 1);
   localparam int QA_W  = $clog2(DESC_LEN);
   localparam int SDEPTH = MAX_ENTRIES * DESC_LEN;
   localparam int SA_W  = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
   localparam int SUM_W = $clog2(DESC_LEN * 255 + 1);
   localparam int DW    = lndp_pkg::DIST_W;

   lndp_pkg::state_type state_ff, state_in;

   // configuration
   logic [13:0] thr_ff, thr_in;
   logic [7:0]  tight_ff, tight_in;
   logic [7:0]  step_ff, step_in;
   logic [8:0]  minc_ff, minc_in;

   // element intake
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [SA_W:0]    rowb_ff, rowb_in;
   logic             lop_ff, lop_in;
   logic [lndp_pkg::RND_W-1:0] rnd_ff, rnd_in;

   // distance pass
   logic [CNT_W-1:0] di_ff, di_in;
   logic [QA_W-1:0]  dj_ff, dj_in;
   logic [SA_W-1:0]  daddr_ff, daddr_in;
   logic [SUM_W-1:0] acc_ff, acc_in;
   logic [DW-1:0]    best_ff, best_in;

   // shared read pipeline stage
   logic             s1v_ff, s1v_in;
   logic             s1last_ff, s1last_in;
   logic [IDX_W-1:0] s1idx_ff, s1idx_in;

   // gather and pick scans
   logic [CNT_W-1:0] si_ff, si_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic [DW:0]      next_ff, next_in;
   logic [15:0]      limit_ff, limit_in;
   logic             widen_ff, widen_in;
   logic [DW-1:0]    x_ff, x_in;
   logic             rgo_ff, rgo_in;
   logic [CNT_W-1:0] pickr_ff, pickr_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic             found_ff, found_in;

   // result staging and output register
   logic             res_kind_ff, res_kind_in;
   logic [IDX_W-1:0] res_idx_ff, res_idx_in;
   logic [DW-1:0]    res_dist_ff, res_dist_in;
   logic             res_match_ff, res_match_in;
   logic             res_full_ff, res_full_in;
   logic             rsp_tvalid_ff, rsp_tvalid_in;
   logic             rsp_kind_ff, rsp_kind_in;
   logic [7:0]       rsp_idx_ff, rsp_idx_in;
   logic [DW-1:0]    rsp_dist_ff, rsp_dist_in;
   logic             rsp_match_ff, rsp_match_in;
   logic             rsp_full_ff, rsp_full_in;

   // memory ports
   logic             s_we;
   logic [SA_W-1:0]  s_waddr, s_raddr;
   logic [7:0]       s_wdata, s_rdata;
   logic             q_we;
   logic [QA_W-1:0]  q_waddr, q_raddr;
   logic [7:0]       q_wdata, q_rdata;
   logic             d_we;
   logic [IDX_W-1:0] d_waddr, d_raddr;
   logic [DW-1:0]    d_wdata, d_rdata;

   lndp_pkg::rem_req_type rem_req;
   lndp_pkg::rem_rsp_type rem_rsp;

   // helpers
   logic             accept;
   logic             op;
   logic [7:0]       elem;
   logic             pos_lt;
   logic [POS_W-1:0] pos_plus;
   logic             tbl_full;
   logic             dist_issue, dist_end;
   logic             scanning, scan_issue, scan_end;
   logic             in_range;
   logic             n_done;
   logic [7:0]       step_eff;
   logic [7:0]       adiff;
   logic [SUM_W-1:0] sum_full;
   logic [DW-1:0]    sum_sat;
   logic [DW:0]      m_val;

   assign op       = req_tuser;
   assign elem     = req_tdata[7:0];
   assign accept   = req_tvalid && (state_ff == lndp_pkg::ST_IDLE);
   assign pos_lt   = pos_ff < POS_W'(DESC_LEN);
   assign pos_plus = pos_lt ? pos_ff + 1'b1 : pos_ff;
   assign tbl_full = cnt_ff == CNT_W'(MAX_ENTRIES);

   assign dist_issue = (state_ff == lndp_pkg::ST_DIST) && (di_ff < cnt_ff);
   assign dist_end   = (state_ff == lndp_pkg::ST_DIST) && !dist_issue && !s1v_ff;
   assign scanning   = (state_ff == lndp_pkg::ST_GATHER) || (state_ff == lndp_pkg::ST_PICK);
   assign scan_issue = scanning && (si_ff < cnt_ff);
   assign scan_end   = scanning && !scan_issue && !s1v_ff;

   assign in_range = (d_rdata >= best_ff) && (16'(d_rdata) <= limit_ff);
   assign n_done   = (16'(n_ff) >= 16'(minc_ff)) || (n_ff == cnt_ff);
   assign step_eff = (step_ff == 8'd0) ? 8'd1 : step_ff;

   assign adiff    = (q_rdata > s_rdata) ? q_rdata - s_rdata : s_rdata - q_rdata;
   assign sum_full = acc_ff + SUM_W'(adiff);
   assign sum_sat  = (32'(sum_full) > 32'(lndp_pkg::DIST_MAX)) ? lndp_pkg::DIST_MAX
                                                                : DW'(sum_full);
   assign m_val    = (rem_rsp.remainder == '0) ? (DW+1)'(x_ff)
                   : (DW+1)'(x_ff) - (DW+1)'(rem_rsp.remainder) + (DW+1)'(step_eff);

   // memories
   assign s_we    = (accept && pos_lt && (op == lndp_pkg::OP_ADD) && !tbl_full) ||
                    ((state_ff == lndp_pkg::ST_FILL) && (lop_ff == lndp_pkg::OP_ADD) && !tbl_full);
   assign s_waddr = SA_W'(rowb_ff + (SA_W+1)'(pos_ff));
   assign s_wdata = accept ? elem : 8'd0;
   assign s_raddr = daddr_ff;

   assign q_we    = (accept && pos_lt && (op == lndp_pkg::OP_QUERY)) ||
                    ((state_ff == lndp_pkg::ST_FILL) && (lop_ff == lndp_pkg::OP_QUERY));
   assign q_waddr = QA_W'(pos_ff);
   assign q_wdata = accept ? elem : 8'd0;
   assign q_raddr = dj_ff;

   assign d_we    = (state_ff == lndp_pkg::ST_DIST) && s1v_ff && s1last_ff;
   assign d_waddr = s1idx_ff;
   assign d_wdata = sum_sat;
   assign d_raddr = si_ff[IDX_W-1:0];

   lndp_ram #(.WIDTH(8), .DEPTH(SDEPTH)) u_store (
      .clock(clock), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
      .raddr(s_raddr), .rdata(s_rdata)
   );

   lndp_ram #(.WIDTH(8), .DEPTH(DESC_LEN)) u_query (
      .clock(clock), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
      .raddr(q_raddr), .rdata(q_rdata)
   );

   lndp_ram #(.WIDTH(DW), .DEPTH(MAX_ENTRIES)) u_dist (
      .clock(clock), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
      .raddr(d_raddr), .rdata(d_rdata)
   );

   always_comb begin
      rem_req.start = rgo_ff;
      if (state_ff == lndp_pkg::ST_DIV) begin
         rem_req.dividend = lndp_pkg::RND_W'(x_ff);
         rem_req.divisor  = lndp_pkg::DVS_W'(step_eff);
      end else begin
         rem_req.dividend = rnd_ff;
         rem_req.divisor  = lndp_pkg::DVS_W'(n_ff);
      end
   end

   lndp_rem u_rem (
      .clock(clock), .reset(reset), .req(rem_req), .rsp(rem_rsp)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lndp_pkg::ST_IDLE: begin
            if (accept && req_tlast) begin
               state_in = (pos_plus < POS_W'(DESC_LEN)) ? lndp_pkg::ST_FILL
                                                       : lndp_pkg::ST_FINISH;
            end
         end
         lndp_pkg::ST_FILL: begin
            if (pos_ff == POS_W'(DESC_LEN - 1)) begin
               state_in = lndp_pkg::ST_FINISH;
            end
         end
         lndp_pkg::ST_FINISH: begin
            if (lop_ff == lndp_pkg::OP_ADD || cnt_ff == '0) begin
               state_in = lndp_pkg::ST_EMIT;
            end else begin
               state_in = lndp_pkg::ST_DIST;
            end
         end
         lndp_pkg::ST_DIST: begin
            if (dist_end) begin
               state_in = lndp_pkg::ST_GATHER;
            end
         end
         lndp_pkg::ST_GATHER: begin
            if (scan_end) begin
               if (n_done) begin
                  state_in = lndp_pkg::ST_MOD;
               end else if (widen_ff) begin
                  state_in = lndp_pkg::ST_DIV;
               end
            end
         end
         lndp_pkg::ST_DIV: begin
            if (rem_rsp.done) begin
               state_in = lndp_pkg::ST_GATHER;
            end
         end
         lndp_pkg::ST_MOD: begin
            if (rem_rsp.done) begin
               state_in = lndp_pkg::ST_PICK;
            end
         end
         lndp_pkg::ST_PICK: begin
            if (scan_end) begin
               state_in = lndp_pkg::ST_EMIT;
            end
         end
         lndp_pkg::ST_EMIT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               state_in = lndp_pkg::ST_IDLE;
            end
         end
         default: state_in = lndp_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      thr_in   = thr_ff;
      tight_in = tight_ff;
      step_in  = step_ff;
      minc_in  = minc_ff;
      pos_in   = pos_ff;
      cnt_in   = cnt_ff;
      rowb_in  = rowb_ff;
      lop_in   = lop_ff;
      rnd_in   = rnd_ff;
      di_in    = di_ff;
      dj_in    = dj_ff;
      daddr_in = daddr_ff;
      acc_in   = acc_ff;
      best_in  = best_ff;
      s1v_in    = dist_issue || scan_issue;
      s1last_in = dj_ff == QA_W'(DESC_LEN - 1);
      s1idx_in  = (state_ff == lndp_pkg::ST_DIST) ? di_ff[IDX_W-1:0] : si_ff[IDX_W-1:0];
      si_in    = si_ff;
      n_in     = n_ff;
      next_in  = next_ff;
      limit_in = limit_ff;
      widen_in = widen_ff;
      x_in     = x_ff;
      rgo_in   = 1'b0;
      pickr_in = pickr_ff;
      k_in     = k_ff;
      found_in = found_ff;
      res_kind_in  = res_kind_ff;
      res_idx_in   = res_idx_ff;
      res_dist_in  = res_dist_ff;
      res_match_in = res_match_ff;
      res_full_in  = res_full_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_dist_in   = rsp_dist_ff;
      rsp_match_in  = rsp_match_ff;
      rsp_full_in   = rsp_full_ff;

      if (csr_wr_en) begin
         case (csr_index)
            lndp_pkg::CSR_MATCH_THR: thr_in   = csr_wdata[13:0];
            lndp_pkg::CSR_TIGHT:     tight_in = csr_wdata[7:0];
            lndp_pkg::CSR_STEP:      step_in  = csr_wdata[7:0];
            lndp_pkg::CSR_MIN_CAND:  minc_in  = csr_wdata[8:0];
            default: ;
         endcase
      end

      if (accept) begin
         pos_in = pos_plus;
         lop_in = op;
         rnd_in = req_tdata[38:8];
      end
      if (state_ff == lndp_pkg::ST_FILL) begin
         pos_in = pos_ff + 1'b1;
      end

      if (state_ff == lndp_pkg::ST_FINISH) begin
         pos_in = '0;
         if (lop_ff == lndp_pkg::OP_ADD) begin
            res_kind_in  = lndp_pkg::KIND_ADD;
            res_idx_in   = tbl_full ? '0 : cnt_ff[IDX_W-1:0];
            res_dist_in  = '0;
            res_match_in = 1'b0;
            res_full_in  = tbl_full;
            if (!tbl_full) begin
               cnt_in  = cnt_ff + 1'b1;
               rowb_in = rowb_ff + (SA_W+1)'(DESC_LEN);
            end
         end else begin
            res_kind_in  = lndp_pkg::KIND_QUERY;
            res_idx_in   = '0;
            res_dist_in  = '0;
            res_match_in = 1'b0;
            res_full_in  = 1'b0;
            di_in    = '0;
            dj_in    = '0;
            daddr_in = '0;
            acc_in   = '0;
            best_in  = lndp_pkg::DIST_MAX;
         end
      end

      if (dist_issue) begin
         daddr_in = daddr_ff + 1'b1;
         if (dj_ff == QA_W'(DESC_LEN - 1)) begin
            dj_in = '0;
            di_in = di_ff + 1'b1;
         end else begin
            dj_in = dj_ff + 1'b1;
         end
      end
      if ((state_ff == lndp_pkg::ST_DIST) && s1v_ff) begin
         if (s1last_ff) begin
            acc_in = '0;
            if (sum_sat < best_ff) begin
               best_in = sum_sat;
            end
         end else begin
            acc_in = sum_full;
         end
      end
      if (dist_end) begin
         si_in    = '0;
         n_in     = '0;
         next_in  = '1;
         limit_in = 16'(best_ff) + 16'(tight_ff);
         widen_in = 1'b0;
      end

      if (scan_issue) begin
         si_in = si_ff + 1'b1;
      end
      if ((state_ff == lndp_pkg::ST_GATHER) && s1v_ff) begin
         if (in_range) begin
            n_in = n_ff + 1'b1;
         end
         if ((16'(d_rdata) > limit_ff) && ((DW+1)'(d_rdata) < next_ff)) begin
            next_in = (DW+1)'(d_rdata);
         end
      end
      if ((state_ff == lndp_pkg::ST_GATHER) && scan_end) begin
         if (n_done) begin
            rgo_in = 1'b1;
         end else if (!widen_ff) begin
            widen_in = 1'b1;
            limit_in = 16'(best_ff) + 16'(step_eff);
            si_in    = '0;
            n_in     = '0;
            next_in  = '1;
         end else begin
            x_in   = DW'(next_ff - (DW+1)'(best_ff));
            rgo_in = 1'b1;
         end
      end
      if ((state_ff == lndp_pkg::ST_DIV) && rem_rsp.done) begin
         limit_in = 16'(best_ff) + 16'(m_val);
         si_in    = '0;
         n_in     = '0;
         next_in  = '1;
      end
      if ((state_ff == lndp_pkg::ST_MOD) && rem_rsp.done) begin
         pickr_in = CNT_W'(rem_rsp.remainder);
         si_in    = '0;
         k_in     = '0;
         found_in = 1'b0;
      end
      if ((state_ff == lndp_pkg::ST_PICK) && s1v_ff && in_range) begin
         k_in = k_ff + 1'b1;
         if (!found_ff && (k_ff == pickr_ff)) begin
            found_in     = 1'b1;
            res_idx_in   = s1idx_ff;
            res_dist_in  = d_rdata;
            res_match_in = d_rdata < thr_ff;
         end
      end

      if ((state_ff == lndp_pkg::ST_EMIT) && (!rsp_tvalid_ff || rsp_tready)) begin
         rsp_tvalid_in = 1'b1;
         rsp_kind_in   = res_kind_ff;
         rsp_idx_in    = 8'(res_idx_ff);
         rsp_dist_in   = res_dist_ff;
         rsp_match_in  = res_match_ff;
         rsp_full_in   = res_full_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= lndp_pkg::ST_IDLE;
         thr_ff        <= lndp_pkg::THR_RST;
         tight_ff      <= lndp_pkg::TIGHT_RST;
         step_ff       <= lndp_pkg::STEP_RST;
         minc_ff       <= lndp_pkg::MINC_RST;
         pos_ff        <= '0;
         cnt_ff        <= '0;
         rowb_ff       <= '0;
         best_ff       <= lndp_pkg::DIST_MAX;
         s1v_ff        <= 1'b0;
         rgo_ff        <= 1'b0;
         widen_ff      <= 1'b0;
         found_ff      <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         thr_ff        <= thr_in;
         tight_ff      <= tight_in;
         step_ff       <= step_in;
         minc_ff       <= minc_in;
         pos_ff        <= pos_in;
         cnt_ff        <= cnt_in;
         rowb_ff       <= rowb_in;
         best_ff       <= best_in;
         s1v_ff        <= s1v_in;
         rgo_ff        <= rgo_in;
         widen_ff      <= widen_in;
         found_ff      <= found_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      lop_ff       <= lop_in;
      rnd_ff       <= rnd_in;
      di_ff        <= di_in;
      dj_ff        <= dj_in;
      daddr_ff     <= daddr_in;
      acc_ff       <= acc_in;
      s1last_ff    <= s1last_in;
      s1idx_ff     <= s1idx_in;
      si_ff        <= si_in;
      n_ff         <= n_in;
      next_ff      <= next_in;
      limit_ff     <= limit_in;
      x_ff         <= x_in;
      pickr_ff     <= pickr_in;
      k_ff         <= k_in;
      res_kind_ff  <= res_kind_in;
      res_idx_ff   <= res_idx_in;
      res_dist_ff  <= res_dist_in;
      res_match_ff <= res_match_in;
      res_full_ff  <= res_full_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_dist_ff  <= rsp_dist_in;
      rsp_match_ff <= rsp_match_in;
      rsp_full_ff  <= rsp_full_in;
   end

   assign req_tready = state_ff == lndp_pkg::ST_IDLE;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {rsp_full_ff, rsp_match_ff, rsp_dist_ff, rsp_idx_ff};

endmodule
